FILE: hdl/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_IMPL(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/dhpq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dhpq_pkg
// Shared constants and types for the deferred handler priority queue.
// ---------------------------------------------------------------------------
package dhpq_pkg;
   localparam int unsigned PRIORITY_LEVELS = 32;
   localparam int unsigned HANDLER_SLOTS = 16;
   localparam int unsigned DATA_BITS = 32;
   localparam int unsigned ID_BITS = 4;
   localparam int unsigned PRIO_BITS = 5;
   localparam int unsigned COUNT_BITS = 16;
   localparam int unsigned OUT_DATA_BITS = 32;

   localparam logic CMD_ACTIVATE = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;
endpackage

FILE: hdl/dhpq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dhpq_ram
// Generic single-port-write, one-read RAM with a registered read.
// ---------------------------------------------------------------------------
module dhpq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/deferred_handler_priority_queue_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deferred_handler_priority_queue_top
// Priority ready queue: per-level handler FIFOs linked in memory, with a
// bitmap of non-empty levels.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake
// req_*     in         start high while busy low
// rsp_*     out        rsp_valid strobe, one cycle, no back pressure
//
// Each transaction steps through accept, memory read, write back and
// response. The dependent read of the handler record and the level head
// through the registered-read RAMs sets this order. Synchronous reset
// clears the bitmap, the queued bits and the counts; RAMs need no clearing.
module deferred_handler_priority_queue_top #(
   parameter int unsigned PRIORITY_LEVELS = dhpq_pkg::PRIORITY_LEVELS,
   parameter int unsigned HANDLER_SLOTS = dhpq_pkg::HANDLER_SLOTS,
   parameter int unsigned DATA_BITS = dhpq_pkg::DATA_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_command,
   input  logic [dhpq_pkg::ID_BITS-1:0]       req_handler_id,
   input  logic [dhpq_pkg::PRIO_BITS-1:0]     req_priority_req,
   input  logic [dhpq_pkg::OUT_DATA_BITS-1:0] req_activation_data,
   input  logic                               req_dispatch_blocked,
   output logic                               rsp_valid,
   output logic                               rsp_dispatched,
   output logic [dhpq_pkg::ID_BITS-1:0]       rsp_out_handler,
   output logic [dhpq_pkg::OUT_DATA_BITS-1:0] rsp_out_data,
   output logic [dhpq_pkg::COUNT_BITS-1:0]    rsp_remaining_count,
   output logic                               rsp_any_pending
);
   localparam int unsigned HB = (HANDLER_SLOTS > 1) ? $clog2(HANDLER_SLOTS) : 1;
   localparam int unsigned LB = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int unsigned CB = dhpq_pkg::COUNT_BITS;
   // Handler record: count, next link, data word.
   localparam int unsigned HW = CB + HB + DATA_BITS;
   // Level record: head, tail.
   localparam int unsigned VW = 2 * HB;
   localparam int unsigned IB = dhpq_pkg::ID_BITS;
   localparam int unsigned OB = dhpq_pkg::OUT_DATA_BITS;

   dhpq_pkg::state_type state_ff, state_in;
   logic                       cmd_ff;
   logic [IB-1:0]              id_ff;
   logic [LB-1:0]              lvl_ff;
   logic [DATA_BITS-1:0]       data_ff;
   logic                       blk_ff;
   logic [PRIORITY_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [HANDLER_SLOTS-1:0]   queued_ff, queued_in;

   // Handler record and level record RAM ports.
   logic          h_we, v_we;
   logic [HB-1:0] h_wa, h_ra, h_ra2, tail_h;
   logic [HW-1:0] h_wd, h_rd;
   logic [LB-1:0] v_wa, v_ra;
   logic [VW-1:0] v_wd, v_rd;
   logic [HW-1:0] h2_rd;
   logic          h2_we;

   // Lowest non-empty level.
   logic [LB-1:0] low_lvl;
   always_comb begin
      low_lvl = '0;
      for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            low_lvl = LB'(i);
         end
      end
   end

   logic          r_valid_ff, r_disp_ff, r_any_ff;
   logic [IB-1:0] r_h_ff;
   logic [OB-1:0] r_d_ff;
   logic [CB-1:0] r_c_ff;

   assign busy = (state_ff != dhpq_pkg::ST_IDLE);

   // Capture the request.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff  <= req_command;
         id_ff   <= req_handler_id;
         blk_ff  <= req_dispatch_blocked;
         data_ff <= DATA_BITS'(req_activation_data);
         if (32'(req_priority_req) >= PRIORITY_LEVELS) begin
            lvl_ff <= LB'(PRIORITY_LEVELS - 1);
         end else begin
            lvl_ff <= LB'(req_priority_req);
         end
      end
   end

   // Read addresses: activate reads its own record and level; dispatch
   // reads the lowest level, then the head handler record.
   assign h_ra = (state_ff == dhpq_pkg::ST_IDLE) ? HB'(req_handler_id) : v_rd[2*HB-1:HB];
   always_comb begin
      v_ra = low_lvl;
      if (req_command == dhpq_pkg::CMD_ACTIVATE) begin
         if (32'(req_priority_req) >= PRIORITY_LEVELS) begin
            v_ra = LB'(PRIORITY_LEVELS - 1);
         end else begin
            v_ra = LB'(req_priority_req);
         end
      end
   end

   dhpq_ram #(.WIDTH(HW), .DEPTH(HANDLER_SLOTS)) u_hrec (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));
   // Mirror copy read at the old tail for link updates.
   dhpq_ram #(.WIDTH(HW), .DEPTH(HANDLER_SLOTS)) u_hlink (
      .clock(clock), .wr_en(h2_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra2), .rd_data(h2_rd));
   dhpq_ram #(.WIDTH(VW), .DEPTH(PRIORITY_LEVELS)) u_lvl (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));

   assign h_ra2 = v_rd[HB-1:0];
   assign tail_h = v_rd[HB-1:0];

   // Record fields; the count of a slot that was never written reads as
   // zero through the written-slot bits.
   logic [CB-1:0]        cnt, cnt_new;
   logic [HB-1:0]        nxt;
   logic [DATA_BITS-1:0] wrd;
   logic                 pend_link;
   logic [HB-1:0]        own_h;
   logic                 lvl_ne;
   logic                 act_ok;
   logic [HANDLER_SLOTS-1:0] cnt_valid_ff;
   logic [HB-1:0]        h_ra_ff;

   assign own_h = HB'(id_ff);
   assign lvl_ne = nonempty_ff[lvl_ff];
   assign act_ok = (32'(id_ff) < HANDLER_SLOTS);

   always_comb begin
      // Count RAM is undefined until written; track written slots.
      cnt = cnt_valid_ff[h_ra_ff] ? h_rd[HW-1:HB+DATA_BITS] : '0;
      nxt = h_rd[HB+DATA_BITS-1:DATA_BITS];
      wrd = h_rd[DATA_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      h_ra_ff <= h_ra;
   end

   // Write-back step: link write of the old tail, whose record is read from
   // the mirror during the read step.
   logic          link_pend_ff;
   logic [HB-1:0] link_addr_ff;
   logic [LB-1:0] disp_lvl_ff;
   logic [HB-1:0] disp_tail_ff;

   always_comb begin
      state_in    = state_ff;
      nonempty_in = nonempty_ff;
      queued_in   = queued_ff;
      h_we = 1'b0; h2_we = 1'b0; v_we = 1'b0;
      h_wa = own_h; h_wd = '0;
      v_wa = lvl_ff; v_wd = v_rd;
      cnt_new = cnt;
      pend_link = 1'b0;
      case (state_ff)
         dhpq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = dhpq_pkg::ST_READ;
            end
         end
         dhpq_pkg::ST_READ: begin
            state_in = dhpq_pkg::ST_WRITE;
            if (cmd_ff == dhpq_pkg::CMD_ACTIVATE) begin
               if (act_ok) begin
                  cnt_new = (cnt == '1) ? cnt : cnt + CB'(1);
                  h_we = 1'b1; h2_we = 1'b1;
                  h_wd = {cnt_new, (queued_ff[own_h] ? nxt : own_h), data_ff};
                  if (!queued_ff[own_h]) begin
                     queued_in[own_h] = 1'b1;
                     nonempty_in[lvl_ff] = 1'b1;
                     v_we = 1'b1;
                     v_wd = lvl_ne ? {v_rd[2*HB-1:HB], own_h} : {own_h, own_h};
                     pend_link = lvl_ne;
                  end
               end
            end else if (!blk_ff && (nonempty_ff != '0)) begin
               // Dispatch: record read is issued now from the level head.
               state_in = dhpq_pkg::ST_WRITE;
            end
         end
         dhpq_pkg::ST_WRITE: begin
            state_in = dhpq_pkg::ST_DONE;
            if (link_pend_ff) begin
               h_we = 1'b1; h2_we = 1'b1;
               h_wa = link_addr_ff;
               h_wd = {h2_rd[HW-1:HB+DATA_BITS], own_h, h2_rd[DATA_BITS-1:0]};
            end
            if (cmd_ff == dhpq_pkg::CMD_DISPATCH && !blk_ff && (nonempty_ff != '0)) begin
               cnt_new = (cnt != '0) ? cnt - CB'(1) : cnt;
               h_we = 1'b1; h2_we = 1'b1;
               h_wa = h_ra_ff;
               h_wd = {cnt_new, nxt, wrd};
               if (cnt_new == '0) begin
                  queued_in[h_ra_ff] = 1'b0;
                  if (disp_tail_ff == h_ra_ff) begin
                     nonempty_in[disp_lvl_ff] = 1'b0;
                  end else begin
                     v_we = 1'b1;
                     v_wa = disp_lvl_ff;
                     v_wd = {nxt, disp_tail_ff};
                  end
               end
            end
         end
         dhpq_pkg::ST_DONE: begin
            state_in = dhpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = dhpq_pkg::ST_IDLE;
         end
      endcase
   end

   // Level captured for a dispatch at the accept step.
   always_ff @(posedge clock) begin
      if (state_ff == dhpq_pkg::ST_IDLE) begin
         disp_lvl_ff <= low_lvl;
      end
      if (state_ff == dhpq_pkg::ST_READ) begin
         disp_tail_ff <= tail_h;
         link_addr_ff <= tail_h;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (state_ff == dhpq_pkg::ST_READ && cmd_ff == dhpq_pkg::CMD_ACTIVATE) begin
         r_disp_ff <= 1'b0;
         r_h_ff    <= id_ff;
         r_d_ff    <= act_ok ? OB'(data_ff) : '0;
         r_c_ff    <= act_ok ? cnt_new : '0;
      end else if (state_ff == dhpq_pkg::ST_WRITE && cmd_ff == dhpq_pkg::CMD_DISPATCH) begin
         r_disp_ff <= !blk_ff && (nonempty_ff != '0);
         r_h_ff    <= (!blk_ff && (nonempty_ff != '0)) ? IB'(h_ra_ff) : '0;
         r_d_ff    <= (!blk_ff && (nonempty_ff != '0)) ? OB'(wrd) : '0;
         r_c_ff    <= (!blk_ff && (nonempty_ff != '0)) ? cnt_new : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhpq_pkg::ST_IDLE;
         nonempty_ff  <= '0;
         queued_ff    <= '0;
         cnt_valid_ff <= '0;
         link_pend_ff <= 1'b0;
         r_valid_ff   <= 1'b0;
         r_any_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         nonempty_ff <= nonempty_in;
         queued_ff   <= queued_in;
         if (h_we) begin
            cnt_valid_ff[h_wa] <= 1'b1;
         end
         link_pend_ff <= (state_ff == dhpq_pkg::ST_READ) && pend_link;
         r_valid_ff   <= (state_ff == dhpq_pkg::ST_WRITE);
         r_any_ff     <= (nonempty_in != '0);
      end
   end

   assign rsp_valid           = r_valid_ff;
   assign rsp_dispatched      = r_disp_ff;
   assign rsp_out_handler     = r_h_ff;
   assign rsp_out_data        = r_d_ff;
   assign rsp_remaining_count = r_c_ff;
   assign rsp_any_pending     = r_any_ff;

`include "assert_macros.svh"
   `CHK_NEXT(a_resp_once, clock, reset, rsp_valid, !rsp_valid)
   `CHK_IMPL(a_busy_resp, clock, reset, rsp_valid, busy)
   `CHK_IMPL(a_queued_level, clock, reset, (queued_ff == '0), (nonempty_ff == '0))
endmodule
